// ----- rtl/core/hslrgb_pkg.sv -----
// Package for the HSL to RGB converter: payload structs, widths, hue
// breakpoints, scaling constants and the hue segment function.
// No dependencies.
`timescale 1ns / 1ps

package hslrgb_pkg;

   localparam int unsigned HueW    = 10;
   localparam int unsigned PctW    = 7;
   localparam int unsigned AngW    = 9;
   localparam int unsigned LevelW  = 14;
   localparam int unsigned SlopeW  = 6;
   localparam int unsigned ChanW   = 20;
   localparam int unsigned ScaledW = 24;
   localparam int unsigned RecipW  = 25;
   localparam int unsigned ColorW  = 8;

   localparam logic [HueW-1:0] HueTurn     = 10'd360;
   localparam logic [HueW-1:0] HueTwoTurns = 10'd720;

   localparam logic [PctW-1:0] PctMax  = 7'd100;
   localparam logic [PctW-1:0] PctHalf = 7'd50;

   localparam logic [AngW-1:0] AngRise   = 9'd60;
   localparam logic [AngW-1:0] AngThird  = 9'd120;
   localparam logic [AngW-1:0] AngFall   = 9'd180;
   localparam logic [AngW-1:0] AngBottom = 9'd240;

   localparam logic [ChanW-1:0] ChanMax = 20'd600000;

   // x*255/600000 == (17*x)/40000; 40000 divide by ceil(2^40/40000) and shift,
   // exact for 17*x below 8.9e7
   localparam logic [RecipW-1:0] RecipMul   = 25'd27487791;
   localparam int unsigned       RecipShift = 40;

   typedef struct packed {
      logic [HueW-1:0] hue;
      logic [PctW-1:0] saturation;
      logic [PctW-1:0] lightness;
   } hslrgb_req_type;

   typedef struct packed {
      logic [ColorW-1:0] red;
      logic [ColorW-1:0] green;
      logic [ColorW-1:0] blue;
   } hslrgb_rsp_type;

   typedef struct packed {
      logic              use_high;
      logic [SlopeW-1:0] slope;
   } hslrgb_seg_type;

   function automatic hslrgb_seg_type hue_segment(input logic [AngW-1:0] angle);
      hslrgb_seg_type seg;
      logic [AngW-1:0] fall;
      fall         = AngBottom - angle;
      seg.use_high = 1'b0;
      seg.slope    = '0;
      priority if (angle < AngRise) begin
         seg.slope = angle[SlopeW-1:0];
      end else if (angle < AngFall) begin
         seg.use_high = 1'b1;
      end else if (angle < AngBottom) begin
         seg.slope = fall[SlopeW-1:0];
      end else begin
         seg.slope = '0;
      end
      return seg;
   endfunction

endpackage

// ----- rtl/core/hsl_to_rgb_converter.sv -----
// HSL to RGB converter, four register stages with per-stage handshake.
// Depends on hslrgb_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   req_valid/req_ready/req_payload carry hue (degrees, wrapped mod 360),
//   saturation and lightness (percent, clamped to 100).
//   rsp_valid/rsp_ready/rsp_payload carry the 8-bit red, green, blue triple.
//   One result per transfer, in order.
// Pipeline: 4 register stages; rsp_valid is the stage 4 valid bit.
// Throughput: one transfer per cycle unless rsp_ready stalls it. Stage 1
//   wraps the hue and clamps; stage 2 forms the high/low levels and hue
//   segments; stage 3 evaluates the three channel ramps (one 14x6
//   multiply each); stage 4 scales by 255/600000 through a reciprocal
//   multiply and is the output register.
// Each stage has its own valid bit and takes new data when it is empty or
//   the next stage moves, so bubbles close up under a stall.
// Stall: while rsp_ready is low the output holds; upstream stages keep
//   filling until the pipe is full, then req_ready drops.
// Reset: synchronous, clears all valid bits; data registers are not reset.
//
module hsl_to_rgb_converter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  hslrgb_pkg::hslrgb_req_type  req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output hslrgb_pkg::hslrgb_rsp_type  rsp_payload
);
   import hslrgb_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;

   logic [AngW-1:0]   hue1_ff, hue1_in;
   logic [PctW-1:0]   sat1_ff, sat1_in;
   logic [PctW-1:0]   lig1_ff, lig1_in;

   logic [LevelW-1:0] high2_ff, high2_in;
   logic [LevelW-1:0] low2_ff, low2_in;
   logic [LevelW-1:0] diff2_ff, diff2_in;
   hslrgb_seg_type    seg2_ff [3];
   hslrgb_seg_type    seg2_in [3];

   logic [ChanW-1:0]  chan3_ff [3];
   logic [ChanW-1:0]  chan3_in [3];

   hslrgb_rsp_type    rsp4_ff, rsp4_in;

   // handshake chain
   assign rdy4      = !v4_ff || rsp_ready;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;

   assign v1_in = rdy1 ? req_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign v4_in = rdy4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // stage 1: wrap hue, clamp percentages
   always_comb begin
      logic [HueW-1:0] hue_wrap;
      priority if (req_payload.hue < HueTurn) begin
         hue_wrap = req_payload.hue;
      end else if (req_payload.hue < HueTwoTurns) begin
         hue_wrap = req_payload.hue - HueTurn;
      end else begin
         hue_wrap = req_payload.hue - HueTwoTurns;
      end
      hue1_in = hue_wrap[AngW-1:0];
      sat1_in = (req_payload.saturation > PctMax) ? PctMax : req_payload.saturation;
      lig1_in = (req_payload.lightness > PctMax) ? PctMax : req_payload.lightness;
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_valid) begin
         hue1_ff <= hue1_in;
         sat1_ff <= sat1_in;
         lig1_ff <= lig1_in;
      end
   end

   // stage 2: levels and hue segments (zero saturation falls out as gray)
   always_comb begin
      logic                low_half;
      logic [PctW-1:0]     op_a;
      logic [PctW:0]       op_b;
      logic [LevelW:0]     prod;
      logic [LevelW:0]     lig_x100;
      logic [LevelW:0]     lig_x200;
      logic [LevelW:0]     high_full;
      logic [LevelW:0]     low_full;
      logic [AngW-1:0]     ang_red;
      logic [AngW-1:0]     ang_blue;
      low_half  = lig1_ff < PctHalf;
      op_a      = low_half ? lig1_ff : sat1_ff;
      op_b      = low_half ? ({1'b0, PctMax} + {1'b0, sat1_ff})
                           : ({1'b0, PctMax} - {1'b0, lig1_ff});
      prod      = {{(LevelW+1-PctW){1'b0}}, op_a} * {{(LevelW-PctW){1'b0}}, op_b};
      lig_x100  = {{(LevelW+1-PctW){1'b0}}, lig1_ff} * (LevelW+1)'(100);
      lig_x200  = {lig_x100[LevelW-1:0], 1'b0};
      high_full = prod + (low_half ? '0 : lig_x100);
      low_full  = lig_x200 - high_full;
      high2_in  = high_full[LevelW-1:0];
      low2_in   = low_full[LevelW-1:0];
      diff2_in  = high2_in - low2_in;
      ang_red   = (hue1_ff < AngBottom) ? hue1_ff + AngThird : hue1_ff - AngBottom;
      ang_blue  = (hue1_ff >= AngThird) ? hue1_ff - AngThird : hue1_ff + AngBottom;
      seg2_in[0] = hue_segment(ang_red);
      seg2_in[1] = hue_segment(hue1_ff);
      seg2_in[2] = hue_segment(ang_blue);
   end

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         high2_ff <= high2_in;
         low2_ff  <= low2_in;
         diff2_ff <= diff2_in;
         seg2_ff  <= seg2_in;
      end
   end

   // stage 3: channel ramps
   always_comb begin
      logic [LevelW-1:0] base;
      for (int k = 0; k < 3; k++) begin
         base        = seg2_ff[k].use_high ? high2_ff : low2_ff;
         chan3_in[k] = {{(ChanW-LevelW){1'b0}}, base} * ChanW'(60)
                     + {{(ChanW-LevelW){1'b0}}, diff2_ff}
                     * {{(ChanW-SlopeW){1'b0}}, seg2_ff[k].slope};
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         chan3_ff <= chan3_in;
      end
   end

   // stage 4: scale by 255/600000, truncating
   always_comb begin
      logic [ScaledW-1:0]        scaled;
      logic [ScaledW+RecipW-1:0] quot_prod;
      logic [ColorW-1:0]         color [3];
      for (int k = 0; k < 3; k++) begin
         scaled    = {chan3_ff[k], 4'b0000} + {4'b0000, chan3_ff[k]};
         quot_prod = {{RecipW{1'b0}}, scaled} * {{ScaledW{1'b0}}, RecipMul};
         color[k]  = quot_prod[RecipShift+ColorW-1 -: ColorW];
      end
      rsp4_in.red   = color[0];
      rsp4_in.green = color[1];
      rsp4_in.blue  = color[2];
   end

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         rsp4_ff <= rsp4_in;
      end
   end

   assign rsp_valid   = v4_ff;
   assign rsp_payload = rsp4_ff;

   // checks
   a_hue_wrapped: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> hue1_ff < AngW'(360))
      else $error("wrapped hue out of range");

   a_level_order: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> low2_ff <= high2_ff)
      else $error("low level above high level");

   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (chan3_ff[0] <= ChanMax && chan3_ff[1] <= ChanMax
                 && chan3_ff[2] <= ChanMax))
      else $error("channel ramp above full scale");

   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !rdy2) |=> (v1_ff && $stable(hue1_ff) && $stable(lig1_ff)))
      else $error("stage 1 lost data under stall");

endmodule

// ----- test/testbench.sv -----
// Testbench for hsl_to_rgb_converter under random bursts and output stalls: a directed
// table, then random colors, checked by typed values or an integer HSL-to-RGB predictor.
// Depends on hslrgb_pkg and the hsl_to_rgb_converter RTL.
`timescale 1ns / 1ps

module testbench;
   import hslrgb_pkg::*;

   typedef struct {
      hslrgb_req_type item;
      bit             typed;
      hslrgb_rsp_type color;
   } dir_row_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   hslrgb_req_type req_payload = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   hslrgb_rsp_type rsp_payload;

   hslrgb_rsp_type expected_colors[$];
   dir_row_type    dir_rows[$];
   int unsigned    error_count = 0;

   int unsigned    rx_mode = 0;
   int unsigned    rx_span = 0;
   int unsigned    rx_phase = 0;

   hsl_to_rgb_converter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int unsigned ramp_level(input int unsigned lo, input int unsigned hi,
                                              input int unsigned ang);
      int unsigned span;
      span = hi - lo;
      if (ang < 60) return lo * 60 + span * ang;
      if (ang < 180) return hi * 60;
      if (ang < 240) return lo * 60 + span * (240 - ang);
      return lo * 60;
   endfunction

   function automatic logic [ColorW-1:0] scale_to_byte(input int unsigned level);
      int unsigned scaled;
      scaled = (level * 255) / 600000;
      return scaled[ColorW-1:0];
   endfunction

   function automatic hslrgb_rsp_type predict_color(input hslrgb_req_type item);
      int unsigned    h, s, l, hi, lo, ang_r, ang_b, gray;
      hslrgb_rsp_type color;
      h = 32'(item.hue);
      s = 32'(item.saturation);
      l = 32'(item.lightness);
      if (h > 359) h = h % 360;
      if (s > 100) s = 100;
      if (l > 100) l = 100;
      if (s == 0) begin
         gray        = (l * 255) / 100;
         color.red   = gray[ColorW-1:0];
         color.green = gray[ColorW-1:0];
         color.blue  = gray[ColorW-1:0];
      end else begin
         if (l < 50) hi = l * (100 + s);
         else hi = (l + s) * 100 - s * l;
         lo          = l * 200 - hi;
         ang_r       = (h < 240) ? h + 120 : h - 240;
         ang_b       = (h >= 120) ? h - 120 : h + 240;
         color.red   = scale_to_byte(ramp_level(lo, hi, ang_r));
         color.green = scale_to_byte(ramp_level(lo, hi, h));
         color.blue  = scale_to_byte(ramp_level(lo, hi, ang_b));
      end
      return color;
   endfunction

   function automatic hslrgb_req_type random_color();
      hslrgb_req_type item;
      int unsigned    marks[15] = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300,
                                    359, 360, 719, 720};
      if ($urandom_range(0, 3) == 0) item.hue = HueW'(marks[$urandom_range(0, 14)]);
      else item.hue = HueW'($urandom_range(0, 1023));
      case ($urandom_range(0, 9))
         0: item.saturation = '0;
         1: item.saturation = PctW'($urandom_range(100, 127));
         default: item.saturation = PctW'($urandom_range(0, 127));
      endcase
      case ($urandom_range(0, 9))
         0: item.lightness = PctW'($urandom_range(49, 50));
         1: item.lightness = PctW'($urandom_range(100, 127));
         2: item.lightness = '0;
         default: item.lightness = PctW'($urandom_range(0, 127));
      endcase
      return item;
   endfunction

   task automatic add_row(input int unsigned h, input int unsigned s, input int unsigned l,
                          input bit typed, input int unsigned r, input int unsigned g,
                          input int unsigned b);
      dir_row_type row;
      row.item.hue        = HueW'(h);
      row.item.saturation = PctW'(s);
      row.item.lightness  = PctW'(l);
      row.typed           = typed;
      row.color.red       = ColorW'(r);
      row.color.green     = ColorW'(g);
      row.color.blue      = ColorW'(b);
      dir_rows.push_back(row);
   endtask

   // Returns at the rising edge of the transfer.
   task automatic send_color(input hslrgb_req_type item, input int unsigned gap);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_colors();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_colors.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (rx_span == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_span = $urandom_range(8, 64);
      end else begin
         rx_span = rx_span - 1;
      end
      rx_phase = rx_phase + 1;
      case (rx_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2: rsp_ready <= ((rx_phase % 3) == 0);
         default: rsp_ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   always @(posedge clock) begin
      hslrgb_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_colors.size() == 0) begin
            $error("unexpected transfer: red %0d green %0d blue %0d",
                   rsp_payload.red, rsp_payload.green, rsp_payload.blue);
            error_count++;
         end else begin
            want = expected_colors.pop_front();
            if (rsp_payload.red !== want.red) begin
               $error("red: expected %0d, actual %0d", want.red, rsp_payload.red);
               error_count++;
            end
            if (rsp_payload.green !== want.green) begin
               $error("green: expected %0d, actual %0d", want.green, rsp_payload.green);
               error_count++;
            end
            if (rsp_payload.blue !== want.blue) begin
               $error("blue: expected %0d, actual %0d", want.blue, rsp_payload.blue);
               error_count++;
            end
         end
      end
   end

   initial begin
      hslrgb_req_type item;
      int unsigned    burst_left;
      int unsigned    gap;

      // grays, primaries, wraps, clamps, black and white
      add_row(0,    0,   0,   1, 0,   0,   0);
      add_row(0,    0,   100, 1, 255, 255, 255);
      add_row(1023, 0,   127, 1, 255, 255, 255);
      add_row(0,    0,   50,  1, 127, 127, 127);
      add_row(0,    100, 50,  1, 255, 0,   0);
      add_row(120,  100, 50,  1, 0,   255, 0);
      add_row(240,  100, 50,  1, 0,   0,   255);
      add_row(60,   100, 50,  1, 255, 255, 0);
      add_row(180,  100, 50,  1, 0,   255, 255);
      add_row(300,  100, 50,  1, 255, 0,   255);
      add_row(360,  100, 50,  1, 255, 0,   0);
      add_row(720,  100, 50,  1, 255, 0,   0);
      add_row(0,    127, 127, 1, 255, 255, 255);
      add_row(0,    100, 0,   1, 0,   0,   0);
      add_row(1000, 127, 0,   1, 0,   0,   0);
      add_row(1023, 100, 50,  0, 0,   0,   0);
      add_row(59,   73,  49,  0, 0,   0,   0);
      add_row(179,  50,  50,  0, 0,   0,   0);
      add_row(239,  127, 25,  0, 0,   0,   0);
      add_row(359,  100, 75,  0, 0,   0,   0);
      add_row(299,  1,   99,  0, 0,   0,   0);
      add_row(719,  64,  101, 0, 0,   0,   0);
      add_row(512,  85,  63,  0, 0,   0,   0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_color(dir_rows[i].item, $urandom_range(0, 2));
         if (dir_rows[i].typed) expected_colors.push_back(dir_rows[i].color);
         else expected_colors.push_back(predict_color(dir_rows[i].item));
      end
      drain_colors();

      burst_left = 0;
      for (int n = 0; n < 1050; n++) begin
         gap = 0;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         end
         burst_left--;
         item = random_color();
         send_color(item, gap);
         expected_colors.push_back(predict_color(item));
         if (n == 500) drain_colors();
      end

      drain_colors();
      repeat (10) @(posedge clock);
      if (error_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
